[src/strip_restart_to_triangle_list_assert.svh]
// Assertion helpers, clocked on clk_i; STRC_ASSERT is gated by the active-low reset.
`ifndef STRIP_RESTART_TO_TRIANGLE_LIST_ASSERT_SVH
`define STRIP_RESTART_TO_TRIANGLE_LIST_ASSERT_SVH

// Plain implication or expression, checked outside reset.
`define STRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Also checked while reset is low.
`define STRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/strc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package strc_pkg;

  localparam int unsigned IdxW        = 32;
  localparam int unsigned NarrowW     = 16;
  localparam logic [IdxW-1:0] RestartReset = 32'h0000_FFFF;

  typedef enum logic [0:0] {
    CfgRestart = 1'b0,
    CfgWide    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IdxW-1:0] older;
    logic [IdxW-1:0] newer;
    logic [1:0]      fill;
    logic            odd;
  } run_state_t;

  typedef struct packed {
    logic            emit;
    logic [IdxW-1:0] corner_a;
    logic [IdxW-1:0] corner_b;
    logic [IdxW-1:0] corner_c;
    logic            from_final;
  } tri_t;

  function automatic logic [IdxW-1:0] fit_index(input logic [IdxW-1:0] v, input logic wide);
    fit_index = wide ? v : {{(IdxW-NarrowW){1'b0}}, v[NarrowW-1:0]};
  endfunction

endpackage

`default_nettype wire

[src/strc_window.sv]
`timescale 1ns / 1ps
`default_nettype none

// Strip window step: next run state and the triangle one index completes.
module strc_window (
  input  var strc_pkg::run_state_t       cur_i,
  input  wire logic [strc_pkg::IdxW-1:0] index_i,
  input  wire logic                      last_i,
  input  wire logic [strc_pkg::IdxW-1:0] restart_i,
  input  wire logic                      wide_i,
  output strc_pkg::run_state_t           nxt_o,
  output strc_pkg::tri_t                 tri_o,
  output logic                           is_cut_o
);

  logic [strc_pkg::IdxW-1:0] idx;
  logic [strc_pkg::IdxW-1:0] cut;
  logic                      distinct;

  assign idx      = strc_pkg::fit_index(index_i, wide_i);
  assign cut      = strc_pkg::fit_index(restart_i, wide_i);
  assign is_cut_o = (idx == cut);
  assign distinct = (cur_i.older != cur_i.newer) && (cur_i.newer != idx) &&
                    (cur_i.older != idx);

  always_comb begin
    nxt_o = cur_i;
    tri_o.emit       = 1'b0;
    tri_o.corner_a   = cur_i.odd ? cur_i.newer : cur_i.older;
    tri_o.corner_b   = cur_i.odd ? cur_i.older : cur_i.newer;
    tri_o.corner_c   = idx;
    tri_o.from_final = last_i;
    if (is_cut_o) begin
      nxt_o.fill = 2'd0;
      nxt_o.odd  = 1'b0;
    end else if (cur_i.fill >= 2'd2) begin
      tri_o.emit  = distinct;
      // degenerate windows still flip the winding parity
      nxt_o.odd   = ~cur_i.odd;
      nxt_o.older = cur_i.newer;
      nxt_o.newer = idx;
    end else begin
      nxt_o.older = cur_i.newer;
      nxt_o.newer = idx;
      nxt_o.fill  = cur_i.fill + 2'd1;
    end
    if (last_i) begin
      nxt_o.fill = 2'd0;
      nxt_o.odd  = 1'b0;
    end
  end

endmodule

`default_nettype wire

[src/strip_restart_to_triangle_list.sv]
// Triangle strip to triangle list with primitive restart.
// Input channel (in_valid_i / in_ready_o) takes one strip index word per
// cycle while in_ready_o is high, with its last_in_buffer flag. Output
// channel (out_valid_o / out_ready_i) delivers one triangle word: corners
// a, b, c and the from_final_index flag. An index equal to the restart
// value, a short run or a degenerate window gives no output word.
// A triangle is registered; it shows in the cycle after the index that
// completes it is taken. Throughput: one index per cycle when not stalled,
// set by the single output register; the run state updates in the same
// cycle the index is accepted. Stall: while an output word waits and
// out_ready_i is low, in_ready_o is low; when out_ready_i is high, a new
// index is taken in the same cycle the pending word leaves.
// Reset: run state is cleared (no indices held, even parity), the restart
// value is 0xFFFF, 16-bit index mode is set. The user writes registers via
// cfg_we_i / cfg_index_i / cfg_data_i while the block is idle (unenforced).
`timescale 1ns / 1ps
`default_nettype none
`include "strip_restart_to_triangle_list_assert.svh"

module strip_restart_to_triangle_list (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_index_i,
  input  wire logic [strc_pkg::IdxW-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [strc_pkg::IdxW-1:0] vertex_index_i,
  input  wire logic                      last_in_buffer_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [strc_pkg::IdxW-1:0]      corner_a_o,
  output logic [strc_pkg::IdxW-1:0]      corner_b_o,
  output logic [strc_pkg::IdxW-1:0]      corner_c_o,
  output logic                           from_final_index_o
);

  logic [strc_pkg::IdxW-1:0] restart_q;
  logic                      wide_q;
  strc_pkg::run_state_t      run_q, run_d;
  strc_pkg::tri_t            tri_d;
  logic                      out_valid_q;
  logic [strc_pkg::IdxW-1:0] a_q, b_q, c_q;
  logic                      final_q;
  logic                      in_acc;
  logic                      is_cut;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= strc_pkg::RestartReset;
      wide_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        strc_pkg::CfgRestart: restart_q <= cfg_data_i;
        strc_pkg::CfgWide:    wide_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  strc_window u_window (
    .cur_i     (run_q),
    .index_i   (vertex_index_i),
    .last_i    (last_in_buffer_i),
    .restart_i (restart_q),
    .wide_i    (wide_q),
    .nxt_o     (run_d),
    .tri_o     (tri_d),
    .is_cut_o  (is_cut)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        run_q       <= run_d;
        out_valid_q <= tri_d.emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && tri_d.emit) begin
      a_q     <= tri_d.corner_a;
      b_q     <= tri_d.corner_b;
      c_q     <= tri_d.corner_c;
      final_q <= tri_d.from_final;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign corner_a_o         = a_q;
  assign corner_b_o         = b_q;
  assign corner_c_o         = c_q;
  assign from_final_index_o = final_q;

  `STRC_ASSERT(a_distinct_corners,
    out_valid_o |-> (corner_a_o != corner_b_o) && (corner_b_o != corner_c_o) &&
      (corner_a_o != corner_c_o),
    "degenerate triangle emitted")
  `STRC_ASSERT_ALWAYS(a_fill_range, !rst_ni || (run_q.fill != 2'd3), "run fill out of range")
  `STRC_ASSERT(a_narrow_newest,
    (out_valid_o && !wide_q) |->
      (corner_c_o[strc_pkg::IdxW-1:strc_pkg::NarrowW] == '0),
    "narrow corner has high bits")
  `STRC_ASSERT(a_cut_clears,
    (in_acc && (is_cut || last_in_buffer_i)) |=> (run_q.fill == 2'd0) && !run_q.odd,
    "run not cleared after restart or last")
endmodule

`default_nettype wire
